### rtl/supersampled_shape_coverage_pixel_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shape coverage pixel block
// Clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUPERSAMPLED_SHAPE_COVERAGE_PIXEL_ASSERT_SVH
`define SUPERSAMPLED_SHAPE_COVERAGE_PIXEL_ASSERT_SVH

// Condition must hold at every clock edge out of reset
`define SSCP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define SSCP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/sscp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_pkg
// Types, constants and helper functions shared by the shape coverage pipeline.
// ----------------------------------------------------------------------------
package sscp_pkg;

    localparam int SAMPLES  = 4;
    localparam int NSAMP    = SAMPLES * SAMPLES;
    localparam int MIN_SIDE = 16;
    localparam int MAX_SIDE = 256;
    // scaled coordinate, signed difference, product and edge value widths
    localparam int CW = 27;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int EW = PW + 2;
    // one sample step is 2 * 65536 on the common scale
    localparam int STEP_SH = 17;

    typedef enum logic [2:0] {
        CFG_TRI_FIRST_TWO = 3'd0,
        CFG_TRI_THIRD     = 3'd1,
        CFG_RECT_A        = 3'd2,
        CFG_RECT_B        = 3'd3,
        CFG_ENABLES       = 3'd4,
        CFG_INK           = 3'd5,
        CFG_SIDE          = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] tri_first_two;
        logic [31:0] tri_third;
        logic [63:0] rect_a;
        logic [63:0] rect_b;
        logic [2:0]  enables;
        logic [23:0] ink;
        logic [8:0]  side;
    } t_cfg;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic [7:0] alpha_out;
    } t_pixel_out;

    // edge geometry of one pixel, handed from sample setup to the edge pipe
    typedef struct packed {
        logic [2:0][DW-1:0] ea;       // bx - ax per edge
        logic [2:0][DW-1:0] eb;       // by - ay per edge
        logic [2:0][DW-1:0] dx;       // first sample x - ax
        logic [2:0][DW-1:0] dy;       // first sample y - ay
        logic [NSAMP-1:0]   rect_hit; // samples covered by enabled rectangles
    } t_geo;

    // covered * 255 / 16, floored
    function automatic logic [7:0] alpha_of(logic [4:0] n);
        logic [12:0] t;
        t = {n, 8'd0} - {8'd0, n};
        return t[11:4];
    endfunction

    // p / 255 floored, exact for p up to 255 * 255
    function automatic logic [7:0] div255(logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

endpackage

### rtl/sscp_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_setup
// Scale shape coordinates, test rectangles per sample and form edge deltas.
// ----------------------------------------------------------------------------
module sscp_setup import sscp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_pixel_in i_pix,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_geo      o_geo
);

    logic [8:0]    side_c;
    logic [11:0]   scale;
    logic [CW-1:0] n_tri [6];
    logic [CW-1:0] n_ra [4];
    logic [CW-1:0] n_rb [4];

    logic          r1_valid;
    logic [7:0]    r1_x, r1_y;
    logic [CW-1:0] r1_tri [6];
    logic [CW-1:0] r1_ra [4];
    logic [CW-1:0] r1_rb [4];

    logic [CW-1:0] px [SAMPLES];
    logic [CW-1:0] py [SAMPLES];
    t_geo          n_geo;
    logic          r2_valid;
    t_geo          r2_geo;

    function automatic logic [CW-1:0] scl(logic [15:0] c, logic [11:0] s);
        logic [27:0] p;
        p = 28'(c) * 28'(s);
        return p[CW-1:0];
    endfunction

    // clamp icon side and scale every Q0.16 coordinate
    always_comb begin
        if (i_cfg.side < 9'(MIN_SIDE)) begin
            side_c = 9'(MIN_SIDE);
        end else if (i_cfg.side > 9'(MAX_SIDE)) begin
            side_c = 9'(MAX_SIDE);
        end else begin
            side_c = i_cfg.side;
        end
        scale = {side_c, 3'd0};
        for (int i = 0; i < 4; i++) begin
            n_tri[i] = scl(i_cfg.tri_first_two[16*i +: 16], scale);
            n_ra[i]  = scl(i_cfg.rect_a[16*i +: 16], scale);
            n_rb[i]  = scl(i_cfg.rect_b[16*i +: 16], scale);
        end
        n_tri[4] = scl(i_cfg.tri_third[15:0], scale);
        n_tri[5] = scl(i_cfg.tri_third[31:16], scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x   <= i_pix.pixel_x;
            r1_y   <= i_pix.pixel_y;
            r1_tri <= n_tri;
            r1_ra  <= n_ra;
            r1_rb  <= n_rb;
        end
    end

    // sample positions, rectangle hits and edge deltas
    always_comb begin
        logic [10:0] vx, vy;
        logic        a_hit, b_hit;
        int          ai, bi;
        for (int s = 0; s < SAMPLES; s++) begin
            vx    = {r1_x, 3'd0} + 11'(2 * s + 1);
            vy    = {r1_y, 3'd0} + 11'(2 * s + 1);
            px[s] = {vx, 16'd0};
            py[s] = {vy, 16'd0};
        end
        for (int sy = 0; sy < SAMPLES; sy++) begin
            for (int sx = 0; sx < SAMPLES; sx++) begin
                a_hit = px[sx] >= r1_ra[0] && px[sx] <= r1_ra[2] &&
                        py[sy] >= r1_ra[1] && py[sy] <= r1_ra[3];
                b_hit = px[sx] >= r1_rb[0] && px[sx] <= r1_rb[2] &&
                        py[sy] >= r1_rb[1] && py[sy] <= r1_rb[3];
                n_geo.rect_hit[sy*SAMPLES + sx] = (i_cfg.enables[1] & a_hit) |
                                                  (i_cfg.enables[2] & b_hit);
            end
        end
        for (int k = 0; k < 3; k++) begin
            ai = 2 * k;
            bi = 2 * ((k + 1) % 3);
            n_geo.ea[k] = {1'b0, r1_tri[bi]} - {1'b0, r1_tri[ai]};
            n_geo.eb[k] = {1'b0, r1_tri[bi+1]} - {1'b0, r1_tri[ai+1]};
            n_geo.dx[k] = {1'b0, px[0]} - {1'b0, r1_tri[ai]};
            n_geo.dy[k] = {1'b0, py[0]} - {1'b0, r1_tri[ai+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_geo <= n_geo;
        end
    end

    assign o_valid = r2_valid;
    assign o_geo   = r2_geo;

endmodule

### rtl/sscp_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_edge
// Evaluate the three triangle edge functions at all samples and merge coverage.
// ----------------------------------------------------------------------------
module sscp_edge import sscp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_geo             i_geo,
    input  logic             i_tri_en,
    output logic             o_valid,
    output logic [NSAMP-1:0] o_mask
);

    // stage 3: edge products at the first sample
    logic                 r3_valid;
    logic signed [PW-1:0] r3_pa [3];
    logic signed [PW-1:0] r3_pb [3];
    logic signed [DW-1:0] r3_ea [3];
    logic signed [DW-1:0] r3_eb [3];
    logic [NSAMP-1:0]     r3_rect;
    // stage 4: base value and per-step terms
    logic                 r4_valid;
    logic signed [EW-1:0] r4_e0 [3];
    logic signed [EW-1:0] r4_row [3][SAMPLES];
    logic signed [EW-1:0] r4_col [3][SAMPLES];
    logic [NSAMP-1:0]     r4_rect;
    // stage 5: row values
    logic                 r5_valid;
    logic signed [EW-1:0] r5_rowv [3][SAMPLES];
    logic signed [EW-1:0] r5_col [3][SAMPLES];
    logic [NSAMP-1:0]     r5_rect;
    // stage 6: coverage mask
    logic                 r6_valid;
    logic [NSAMP-1:0]     r6_mask;

    logic signed [EW-1:0] n_row [3][SAMPLES];
    logic signed [EW-1:0] n_col [3][SAMPLES];
    logic [NSAMP-1:0]     n_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    // multiply edge direction by sample offset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_pa[k] <= $signed(i_geo.ea[k]) * $signed(i_geo.dy[k]);
                r3_pb[k] <= $signed(i_geo.eb[k]) * $signed(i_geo.dx[k]);
                r3_ea[k] <= $signed(i_geo.ea[k]);
                r3_eb[k] <= $signed(i_geo.eb[k]);
            end
            r3_rect <= i_geo.rect_hit;
        end
    end

    // step multiples: 0, 1, 2 and 3 sample steps
    always_comb begin
        logic signed [EW-1:0] a1, b1;
        for (int k = 0; k < 3; k++) begin
            a1 = EW'(r3_ea[k]) <<< STEP_SH;
            b1 = EW'(r3_eb[k]) <<< STEP_SH;
            n_row[k][0] = '0;
            n_row[k][1] = a1;
            n_row[k][2] = a1 <<< 1;
            n_row[k][3] = a1 + (a1 <<< 1);
            n_col[k][0] = '0;
            n_col[k][1] = b1;
            n_col[k][2] = b1 <<< 1;
            n_col[k][3] = b1 + (b1 <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_e0[k] <= EW'(r3_pa[k]) - EW'(r3_pb[k]);
            end
            r4_row  <= n_row;
            r4_col  <= n_col;
            r4_rect <= r3_rect;
        end
    end

    // add the row term to the base value
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int s = 0; s < SAMPLES; s++) begin
                    r5_rowv[k][s] <= r4_e0[k] + r4_row[k][s];
                end
            end
            r5_col  <= r4_col;
            r5_rect <= r4_rect;
        end
    end

    // sign test per sample; boundary and degenerate cases count as inside
    always_comb begin
        logic signed [EW-1:0] v;
        logic                 neg, pos;
        for (int sy = 0; sy < SAMPLES; sy++) begin
            for (int sx = 0; sx < SAMPLES; sx++) begin
                neg = 1'b0;
                pos = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    v   = r5_rowv[k][sy] - r5_col[k][sx];
                    neg = neg | v[EW-1];
                    pos = pos | (!v[EW-1] && (v != '0));
                end
                n_mask[sy*SAMPLES + sx] = (i_tri_en & !(neg & pos)) |
                                          r5_rect[sy*SAMPLES + sx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_mask <= n_mask;
        end
    end

    assign o_valid = r6_valid;
    assign o_mask  = r6_mask;

endmodule

### rtl/sscp_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscp_shade
// Count covered samples, derive alpha and premultiply the ink color.
// ----------------------------------------------------------------------------
module sscp_shade import sscp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NSAMP-1:0] i_mask,
    input  logic [23:0]      i_ink,
    output logic             o_valid,
    output t_pixel_out       o_pix
);

    logic        r7_valid, r8_valid, r9_valid;
    logic [7:0]  r7_alpha, r8_alpha;
    logic [15:0] r8_prod [3];
    t_pixel_out  r9_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
        end else if (i_en) begin
            r7_valid <= i_valid;
            r8_valid <= r7_valid;
            r9_valid <= r8_valid;
        end
    end

    // alpha from sample count
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_alpha <= alpha_of(5'($countones(i_mask)));
        end
    end

    // ink channel times alpha
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r8_prod[c] <= 16'(i_ink[8*c +: 8]) * 16'(r7_alpha);
            end
            r8_alpha <= r7_alpha;
        end
    end

    // divide by 255 into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_pix.red_out   <= div255(r8_prod[0]);
            r9_pix.green_out <= div255(r8_prod[1]);
            r9_pix.blue_out  <= div255(r8_prod[2]);
            r9_pix.alpha_out <= r8_alpha;
        end
    end

    assign o_valid = r9_valid;
    assign o_pix   = r9_pix;

endmodule

### rtl/supersampled_shape_coverage_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supersampled_shape_coverage_pixel
// 4x4 supersampled coverage of a triangle and two rectangles, one pixel per item.
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries a pixel coordinate; output
// channel o_out_valid/i_out_ready returns its premultiplied BGRA color.
// Shape, ink and icon side registers are written through the i_cfg_* channel,
// which is always ready; write it only while no item is in flight.
// The pipeline is nine register stages: coordinate scaling, rectangle tests
// and edge deltas, edge products, step terms, row sums, per-sample sign test,
// sample count to alpha, ink multiply, divide by 255 into the output register.
// Throughput is one item per cycle while the receiver keeps up. All stages
// move together: when the output holds an item that the receiver does not
// take, the whole pipe holds and o_in_ready drops, nothing is lost or
// repeated. Reset clears all stage valid bits and loads the registers with
// no shapes enabled, white ink and an icon side of 16.
// ----------------------------------------------------------------------------
`include "supersampled_shape_coverage_pixel_assert.svh"

module supersampled_shape_coverage_pixel import sscp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pixel_in   i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pixel_out  o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             pipe_en;
    logic             geo_valid, mask_valid;
    t_geo             geo;
    logic [NSAMP-1:0] mask;

    assign o_cfg_ready = 1'b1;
    assign pipe_en     = !o_out_valid || i_out_ready;
    assign o_in_ready  = pipe_en;

    // register writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tri_first_two <= '0;
            r_cfg.tri_third     <= '0;
            r_cfg.rect_a        <= '0;
            r_cfg.rect_b        <= '0;
            r_cfg.enables       <= '0;
            r_cfg.ink           <= 24'hFFFFFF;
            r_cfg.side          <= 9'(MIN_SIDE);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TRI_FIRST_TWO: r_cfg.tri_first_two <= i_cfg_data;
                CFG_TRI_THIRD:     r_cfg.tri_third     <= i_cfg_data[31:0];
                CFG_RECT_A:        r_cfg.rect_a        <= i_cfg_data;
                CFG_RECT_B:        r_cfg.rect_b        <= i_cfg_data;
                CFG_ENABLES:       r_cfg.enables       <= i_cfg_data[2:0];
                CFG_INK:           r_cfg.ink           <= i_cfg_data[23:0];
                CFG_SIDE:          r_cfg.side          <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    sscp_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_pix   (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (geo_valid),
        .o_geo   (geo)
    );

    sscp_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (geo_valid),
        .i_geo    (geo),
        .i_tri_en (r_cfg.enables[0]),
        .o_valid  (mask_valid),
        .o_mask   (mask)
    );

    sscp_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (mask_valid),
        .i_mask  (mask),
        .i_ink   (r_cfg.ink),
        .o_valid (o_out_valid),
        .o_pix   (o_out_data)
    );

    // premultiplied channels never exceed alpha
    `SSCP_ASSERT_IMPL(a_color_le_alpha, o_out_valid,
        o_out_data.red_out <= o_out_data.alpha_out &&
        o_out_data.green_out <= o_out_data.alpha_out &&
        o_out_data.blue_out <= o_out_data.alpha_out,
        "premultiplied color above alpha")
    // a fully transparent pixel carries no color
    `SSCP_ASSERT_IMPL(a_zero_alpha_dark, o_out_valid && o_out_data.alpha_out == 8'd0,
        o_out_data.red_out == 8'd0 && o_out_data.green_out == 8'd0 &&
        o_out_data.blue_out == 8'd0,
        "color on a transparent pixel")
    // no shape enabled means nothing covered
    `SSCP_ASSERT_IMPL(a_no_shapes, mask_valid && r_cfg.enables == 3'd0, mask == '0,
        "coverage without an enabled shape")

endmodule

### dv/supersampled_shape_coverage_pixel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supersampled_shape_coverage_pixel_tb
// Streams pixel coordinates through the coverage block under several shape,
// ink and icon-side settings. A scoreboard predicts the 4x4 sample coverage
// and premultiplied color of each accepted pixel and checks results in order.
// ----------------------------------------------------------------------------
module supersampled_shape_coverage_pixel_tb;
    import sscp_pkg::*;

    // -------------------------------------------------------------------------
    // Coverage predictor and ordered store of expected colors
    // -------------------------------------------------------------------------
    class pixel_color_scoreboard;
        logic [63:0] tri_ab;
        logic [31:0] tri_c;
        logic [63:0] rect_a;
        logic [63:0] rect_b;
        logic [2:0]  enables;
        logic [23:0] ink;
        logic [8:0]  side;
        t_pixel_out  pending_colors[$];
        int          mismatch_count;

        function void reset_regs();
            tri_ab = '0;
            tri_c = '0;
            rect_a = '0;
            rect_b = '0;
            enables = '0;
            ink = 24'hFFFFFF;
            side = 9'd16;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                CFG_TRI_FIRST_TWO: tri_ab = value;
                CFG_TRI_THIRD:     tri_c = value[31:0];
                CFG_RECT_A:        rect_a = value;
                CFG_RECT_B:        rect_b = value;
                CFG_ENABLES:       enables = value[2:0];
                CFG_INK:           ink = value[23:0];
                CFG_SIDE:          side = value[8:0];
                default: ;
            endcase
        endfunction

        function int sgn(longint v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function int edge_dir(longint ax, longint ay, longint bx, longint by,
                              longint px, longint py);
            return sgn((bx - ax) * (py - ay) - (by - ay) * (px - ax));
        endfunction

        function bit in_box(logic [63:0] r, longint scale, longint px, longint py);
            return px >= r[15:0] * scale && px <= r[47:32] * scale &&
                   py >= r[31:16] * scale && py <= r[63:48] * scale;
        endfunction

        function t_pixel_out color_of(t_pixel_in pix);
            longint scale, px, py;
            longint t[6];
            int d1, d2, d3, covered, eff_side;
            bit neg, pos, hit;
            logic [7:0] alpha;
            t_pixel_out res;
            eff_side = side < 16 ? 16 : (side > 256 ? 256 : side);
            scale = 8 * eff_side;
            for (int i = 0; i < 4; i++) t[i] = tri_ab[16*i +: 16] * scale;
            t[4] = tri_c[15:0] * scale;
            t[5] = tri_c[31:16] * scale;
            covered = 0;
            for (int sy = 0; sy < 4; sy++) begin
                py = (8 * longint'(pix.pixel_y) + 2 * sy + 1) * 65536;
                for (int sx = 0; sx < 4; sx++) begin
                    px = (8 * longint'(pix.pixel_x) + 2 * sx + 1) * 65536;
                    d1 = edge_dir(t[0], t[1], t[2], t[3], px, py);
                    d2 = edge_dir(t[2], t[3], t[4], t[5], px, py);
                    d3 = edge_dir(t[4], t[5], t[0], t[1], px, py);
                    neg = d1 < 0 || d2 < 0 || d3 < 0;
                    pos = d1 > 0 || d2 > 0 || d3 > 0;
                    hit = (enables[0] && !(neg && pos)) ||
                          (enables[1] && in_box(rect_a, scale, px, py)) ||
                          (enables[2] && in_box(rect_b, scale, px, py));
                    if (hit) covered++;
                end
            end
            alpha = 8'(covered * 255 / 16);
            res.alpha_out = alpha;
            res.blue_out  = 8'(ink[23:16] * alpha / 255);
            res.green_out = 8'(ink[15:8] * alpha / 255);
            res.red_out   = 8'(ink[7:0] * alpha / 255);
            return res;
        endfunction

        function void note_pixel(t_pixel_in pix);
            pending_colors.push_back(color_of(pix));
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            mismatch_count++;
        endtask

        task check_color(t_pixel_out got);
            t_pixel_out want;
            if (pending_colors.size() == 0) begin
                report("result with nothing pending", int'(got), 0);
                return;
            end
            want = pending_colors.pop_front();
            if (got.blue_out != want.blue_out)   report("blue", got.blue_out, want.blue_out);
            if (got.green_out != want.green_out) report("green", got.green_out, want.green_out);
            if (got.red_out != want.red_out)     report("red", got.red_out, want.red_out);
            if (got.alpha_out != want.alpha_out) report("alpha", got.alpha_out, want.alpha_out);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_pixel_in   in_data;
    logic        out_valid;
    logic        out_ready;
    t_pixel_out  out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    pixel_color_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;

    supersampled_shape_coverage_pixel dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Clock
    always begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted result
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_color(out_data);
    end

    // Run limit
    initial begin
        #2000000;
        $display("supersampled_shape_coverage_pixel_tb: FAIL");
        $finish;
    end

    // Offer one pixel, with random idle before it; hold until accepted
    task automatic send_pixel(logic [7:0] x, logic [7:0] y);
        t_pixel_in pix;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pix.pixel_x = x;
        pix.pixel_y = y;
        in_valid <= 1'b1;
        in_data <= pix;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(pix);
    endtask

    // Drop valid and wait for the pipe to drain
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_colors.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    function automatic logic [63:0] pack4(int a, int b, int c, int d);
        return {d[15:0], c[15:0], b[15:0], a[15:0]};
    endfunction

    // Random shape setup; rectangle A gets ordered bounds, the rest is fully random
    task automatic random_shapes();
        int l, t, r, b;
        write_reg(CFG_TRI_FIRST_TWO, {$urandom, $urandom});
        write_reg(CFG_TRI_THIRD, 64'($urandom));
        l = $urandom_range(65535); r = $urandom_range(65535);
        t = $urandom_range(65535); b = $urandom_range(65535);
        write_reg(CFG_RECT_A, pack4(l < r ? l : r, t < b ? t : b,
                                    l < r ? r : l, t < b ? b : t));
        write_reg(CFG_RECT_B, {$urandom, $urandom});
        write_reg(CFG_ENABLES, 64'($urandom_range(7)));
        write_reg(CFG_INK, 64'($urandom));
        write_reg(CFG_SIDE, 64'($urandom_range(511)));
    endtask

    // Pixels mostly inside the icon, sometimes anywhere
    task automatic random_pixels(int count);
        int lim;
        for (int i = 0; i < count; i++) begin
            lim = (sb.side < 16) ? 16 : (sb.side > 256 ? 256 : sb.side);
            if ($urandom_range(9) == 0)
                send_pixel(8'($urandom), 8'($urandom));
            else
                send_pixel(8'($urandom_range(lim - 1)), 8'($urandom_range(lim - 1)));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TRI_FIRST_TWO;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: nothing enabled gives all zero
        send_pixel(0, 0);
        send_pixel(255, 255);
        drain();

        // Triangle boundary cases at the largest side
        write_reg(CFG_TRI_FIRST_TWO, pack4(0, 0, 65535, 0));
        write_reg(CFG_TRI_THIRD, pack4(0, 65535, 0, 0));
        write_reg(CFG_ENABLES, 3'b001);
        write_reg(CFG_SIDE, 256);
        send_pixel(0, 0);
        send_pixel(128, 127);
        send_pixel(255, 0);
        send_pixel(0, 255);
        send_pixel(100, 200);
        drain();

        // Degenerate triangles: all vertices equal, then collinear
        write_reg(CFG_TRI_FIRST_TWO, pack4(4096, 4096, 4096, 4096));
        write_reg(CFG_TRI_THIRD, pack4(4096, 4096, 0, 0));
        send_pixel(3, 9);
        send_pixel(255, 255);
        drain();
        write_reg(CFG_TRI_FIRST_TWO, pack4(0, 0, 32768, 32768));
        write_reg(CFG_TRI_THIRD, pack4(65535, 65535, 0, 0));
        write_reg(CFG_SIDE, 16);
        send_pixel(5, 5);
        send_pixel(5, 6);
        drain();

        // Rectangles: inclusive bounds, empty when inverted, side clamps
        write_reg(CFG_RECT_A, pack4(0, 0, 65535, 65535));
        write_reg(CFG_RECT_B, pack4(40000, 0, 10000, 65535));
        write_reg(CFG_ENABLES, 3'b110);
        write_reg(CFG_INK, 24'h80FF00);
        write_reg(CFG_SIDE, 0);
        send_pixel(0, 0);
        send_pixel(15, 15);
        send_pixel(16, 3);
        drain();
        write_reg(CFG_SIDE, 511);
        write_reg(CFG_RECT_A, pack4(4096, 8192, 4096, 8192));
        write_reg(CFG_ENABLES, 3'b111);
        send_pixel(16, 32);
        send_pixel(255, 128);
        drain();
        write_reg(CFG_INK, 24'h000000);
        send_pixel(1, 1);
        drain();
        write_reg(t_cfg_idx'(3'd7), 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Random phases with varied idling
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            random_shapes();
            if (phase == 2) begin
                // Long receiver hold-off while the sender keeps offering
                hold_off_cycles = 60;
                random_pixels(30);
            end
            random_pixels(55);
            drain();
        end

        if (sb.mismatch_count == 0 && sb.pending_colors.size() == 0)
            $display("supersampled_shape_coverage_pixel_tb: PASS");
        else
            $display("supersampled_shape_coverage_pixel_tb: FAIL");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/sscp_pkg.sv
rtl/sscp_setup.sv
rtl/sscp_edge.sv
rtl/sscp_shade.sv
rtl/supersampled_shape_coverage_pixel.sv
dv/supersampled_shape_coverage_pixel_tb.sv
